// ===== rtl/core/trrs_pkg.sv =====
// shared types and constants for the tick rate ratio sampler
// used by every module and interface of the block; no dependencies

package trrs_pkg;

  // ring size default and field widths
  localparam int unsigned RingDepth = 64;
  localparam int unsigned MsW       = 32;
  localparam int unsigned ReqW      = 7;
  localparam int unsigned ScaleW    = 10;
  localparam int unsigned CapW      = 22;
  localparam int unsigned DivCntW   = 5;

  localparam logic [MsW-1:0]    GuestCap   = 32'd4000000;
  localparam logic [ScaleW-1:0] ScaleReset = 10'd1000;

  // opcodes of an input beat
  localparam logic OpTick     = 1'b0;
  localparam logic OpSnapshot = 1'b1;

  // register indexes on the config port
  localparam logic RegEnable = 1'b0;
  localparam logic RegScale  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIVGO,
    ST_DIV,
    ST_PUSH,
    ST_RD,
    ST_LOAD,
    ST_SEND
  } state_e;

  typedef struct packed {
    logic           start;
    logic [MsW-1:0] dividend;
    logic [MsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [MsW-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic push;
    logic rd_en;
  } ring_ctl_t;

endpackage

// ===== rtl/core/trrs_if.sv =====
// valid/ready channel interfaces for tick and snapshot beats in and sample beats out
// depends on trrs_pkg for field widths

interface trrs_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [trrs_pkg::MsW-1:0]     guest_ms;
  logic [trrs_pkg::MsW-1:0]     host_ms;
  logic [trrs_pkg::ReqW-1:0]    max_count;

  modport source (output valid, output opcode, output guest_ms, output host_ms,
                  output max_count, input ready);
  modport sink   (input valid, input opcode, input guest_ms, input host_ms,
                  input max_count, output ready);
endinterface

interface trrs_out_if;
  logic                     valid;
  logic                     ready;
  logic [trrs_pkg::MsW-1:0] sample_value;
  logic                     last_sample;

  modport source (output valid, output sample_value, output last_sample, input ready);
  modport sink   (input valid, input sample_value, input last_sample, output ready);
endinterface

// ===== rtl/core/trrs_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// depends on trrs_pkg for the request and response structs

module trrs_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  trrs_pkg::div_req_t req_i,
  output trrs_pkg::div_rsp_t rsp_o
);

  localparam int unsigned W = trrs_pkg::MsW;

  logic [W-1:0]                 rem_q, rem_d;
  logic [W-1:0]                 quo_q, quo_d;
  logic [W-1:0]                 dvs_q;
  logic [trrs_pkg::DivCntW-1:0] cnt_q;
  logic                         busy_q, done_q;
  logic [W:0]                   part;
  logic [W:0]                   trial;

  // one shift-subtract step
  always_comb begin
    part  = {rem_q, quo_q[W-1]};
    trial = part - {1'b0, dvs_q};
    if (!trial[W]) begin
      rem_d = trial[W-1:0];
      quo_d = {quo_q[W-2:0], 1'b1};
    end else begin
      rem_d = part[W-1:0];
      quo_d = {quo_q[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == '1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== rtl/core/trrs_ring.sv =====
// sample ring: memory with registered read, write pointer and saturating fill count
// depends on trrs_pkg for the control struct and data width

module trrs_ring #(
  parameter int unsigned RING_DEPTH = trrs_pkg::RingDepth,
  parameter int unsigned PW         = $clog2(RING_DEPTH),
  parameter int unsigned CW         = $clog2(RING_DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  trrs_pkg::ring_ctl_t      ctl_i,
  input  logic [trrs_pkg::MsW-1:0] wdata_i,
  input  logic [PW-1:0]            raddr_i,
  output logic [trrs_pkg::MsW-1:0] rdata_o,
  output logic [PW-1:0]            wptr_o,
  output logic [CW-1:0]            count_o
);

  localparam logic [PW-1:0] LastPtr = PW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] Full    = CW'(RING_DEPTH);

  logic [trrs_pkg::MsW-1:0] mem [RING_DEPTH];
  logic [trrs_pkg::MsW-1:0] rdata_q;
  logic [PW-1:0]            wptr_q;
  logic [CW-1:0]            count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      count_q <= '0;
    end else if (ctl_i.push) begin
      wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      if (count_q != Full) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign wptr_o  = wptr_q;
  assign count_o = count_q;

endmodule

// ===== rtl/core/tick_rate_ratio_sampler.sv =====
// top level of the tick rate ratio sampler: sequencer, config registers, output register
// depends on trrs_pkg, trrs_if, trrs_div and trrs_ring
//
//   channel  dir  handshake          payload
//   in_i     in   valid/ready        opcode, guest_ms, host_ms, max_count
//   out_o    out  valid/ready        sample_value, last_sample
//   apb      in   psel/penable/pw..  paddr 3 bits, 32-bit data, pready tied high
//
// a tick beat ends at the accept when disabled or on the latching tick; with a zero
// host difference it goes on to a ring push, else the sequencer steps through the
// multiply, the divider start, the divide steps, the done flag and the ring push
// a snapshot returns its samples one at a time, each by memory read, output load and
// send; a stall on out_o holds the output register and the sequencer
// in_i.ready is high only while the sequencer is idle
// reset clears control state, pointers and the fill count; the ring itself is not cleared

module tick_rate_ratio_sampler #(
  parameter int unsigned RING_DEPTH = trrs_pkg::RingDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  trrs_in_if.sink     in_i,
  trrs_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned PW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned W  = trrs_pkg::MsW;
  localparam int unsigned SW = trrs_pkg::ScaleW;
  localparam logic [PW-1:0] LastPtr = PW'(RING_DEPTH - 1);
  localparam logic [CW:0]   DepthX  = (CW + 1)'(RING_DEPTH);

  trrs_pkg::state_e state_q, state_d;

  // config registers
  logic          enable_q;
  logic [SW-1:0] scale_q;
  logic          started_q;
  logic          cfg_wr;

  // tick datapath
  logic [W-1:0]                 prev_g_q, prev_h_q;
  logic [W-1:0]                 gdiff, hdiff;
  logic [trrs_pkg::CapW-1:0]    gd_q, gd_cap;
  logic [W-1:0]                 hd_q;
  logic [W-1:0]                 prod_q, prod_w;
  logic [W-1:0]                 ratio_q;

  // snapshot control
  logic [CW-1:0]  remain_q;
  logic [PW-1:0]  rd_addr_q;
  logic [CW-1:0]  snap_cnt;
  logic [trrs_pkg::ReqW-1:0] stored_x;
  logic [CW:0]    first_x;
  logic [PW-1:0]  first_ptr;

  // output register
  logic         out_valid_q;
  logic [W-1:0] out_data_q;
  logic         out_last_q;

  logic in_fire;
  logic out_fire;

  trrs_pkg::div_req_t  div_req;
  trrs_pkg::div_rsp_t  div_rsp;
  trrs_pkg::ring_ctl_t ring_ctl;
  logic [W-1:0]        ring_rdata;
  logic [PW-1:0]       ring_wptr;
  logic [CW-1:0]       ring_count;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  always_comb begin
    unique case (paddr[2])
      trrs_pkg::RegEnable: prdata = {31'b0, enable_q};
      trrs_pkg::RegScale:  prdata = {{(32 - SW){1'b0}}, scale_q};
      default:             prdata = '0;
    endcase
  end

  // wrapping differences and the guest cap
  assign gdiff  = in_i.guest_ms - prev_g_q;
  assign hdiff  = in_i.host_ms - prev_h_q;
  assign gd_cap = (gdiff > trrs_pkg::GuestCap) ? trrs_pkg::CapW'(trrs_pkg::GuestCap)
                                               : trrs_pkg::CapW'(gdiff);
  // 22 x 10 bits fits 32 bits
  assign prod_w = W'(gd_q) * W'(scale_q);

  // snapshot length and oldest slot to read
  assign stored_x  = trrs_pkg::ReqW'(ring_count);
  assign snap_cnt  = (in_i.max_count < stored_x) ? CW'(in_i.max_count) : ring_count;
  always_comb begin
    first_x = (CW + 1)'(ring_wptr) + DepthX - (CW + 1)'(snap_cnt);
    if (first_x >= DepthX) begin
      first_x = first_x - DepthX;
    end
    first_ptr = PW'(first_x);
  end

  // sequencer
  always_comb begin
    state_d        = state_q;
    div_req.start  = 1'b0;
    ring_ctl.push  = 1'b0;
    ring_ctl.rd_en = 1'b0;
    unique case (state_q)
      trrs_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_i.opcode == trrs_pkg::OpTick) begin
            if (enable_q && started_q) begin
              state_d = (hdiff == '0) ? trrs_pkg::ST_PUSH : trrs_pkg::ST_MUL;
            end
          end else if (snap_cnt != '0) begin
            state_d = trrs_pkg::ST_RD;
          end
        end
      end
      trrs_pkg::ST_MUL:   state_d = trrs_pkg::ST_DIVGO;
      trrs_pkg::ST_DIVGO: begin
        div_req.start = 1'b1;
        state_d       = trrs_pkg::ST_DIV;
      end
      trrs_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_d = trrs_pkg::ST_PUSH;
        end
      end
      trrs_pkg::ST_PUSH: begin
        ring_ctl.push = 1'b1;
        state_d       = trrs_pkg::ST_IDLE;
      end
      trrs_pkg::ST_RD: begin
        ring_ctl.rd_en = 1'b1;
        state_d        = trrs_pkg::ST_LOAD;
      end
      trrs_pkg::ST_LOAD:  state_d = trrs_pkg::ST_SEND;
      trrs_pkg::ST_SEND: begin
        if (out_fire) begin
          state_d = (remain_q == '0) ? trrs_pkg::ST_IDLE : trrs_pkg::ST_RD;
        end
      end
      default: state_d = trrs_pkg::ST_IDLE;
    endcase
  end

  assign div_req.dividend = prod_q;
  assign div_req.divisor  = hd_q;

  assign in_i.ready   = (state_q == trrs_pkg::ST_IDLE);
  assign out_o.valid  = out_valid_q;
  assign out_o.sample_value = out_data_q;
  assign out_o.last_sample  = out_last_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= trrs_pkg::ST_IDLE;
      enable_q    <= 1'b0;
      scale_q     <= trrs_pkg::ScaleReset;
      started_q   <= 1'b0;
      prev_g_q    <= '0;
      prev_h_q    <= '0;
      remain_q    <= '0;
      rd_addr_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        unique case (paddr[2])
          trrs_pkg::RegEnable: begin
            enable_q <= pwdata[0];
            // disabling drops the latched counts
            if (!pwdata[0]) begin
              started_q <= 1'b0;
            end
          end
          trrs_pkg::RegScale: scale_q <= pwdata[SW-1:0];
          default: ;
        endcase
      end
      if (state_q == trrs_pkg::ST_IDLE && in_fire) begin
        if (in_i.opcode == trrs_pkg::OpTick) begin
          if (enable_q) begin
            started_q <= 1'b1;
            prev_g_q  <= in_i.guest_ms;
            prev_h_q  <= in_i.host_ms;
          end
        end else begin
          remain_q  <= snap_cnt;
          rd_addr_q <= first_ptr;
        end
      end
      if (state_q == trrs_pkg::ST_LOAD) begin
        out_valid_q <= 1'b1;
        remain_q    <= remain_q - 1'b1;
        rd_addr_q   <= (rd_addr_q == LastPtr) ? '0 : rd_addr_q + 1'b1;
      end
      if (state_q == trrs_pkg::ST_SEND && out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == trrs_pkg::ST_IDLE && in_fire) begin
      gd_q <= gd_cap;
      hd_q <= hdiff;
      // zero host difference reads as unity
      ratio_q <= {{(W - SW){1'b0}}, scale_q};
    end
    if (state_q == trrs_pkg::ST_MUL) begin
      prod_q <= prod_w;
    end
    if (state_q == trrs_pkg::ST_DIV && div_rsp.done) begin
      ratio_q <= div_rsp.quotient;
    end
    if (state_q == trrs_pkg::ST_LOAD) begin
      out_data_q <= ring_rdata;
      out_last_q <= (remain_q == CW'(1));
    end
  end

  trrs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  trrs_ring #(
    .RING_DEPTH (RING_DEPTH),
    .PW         (PW),
    .CW         (CW)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ring_ctl),
    .wdata_i (ratio_q),
    .raddr_i (rd_addr_q),
    .rdata_o (ring_rdata),
    .wptr_o  (ring_wptr),
    .count_o (ring_count)
  );

endmodule
